FILE: hdl/tww_pkg.sv
// ----------------------------------------------------------------------------
// tww_pkg
// Shared types, action codes and constants of the task wait/wakeup scheduler.
// ----------------------------------------------------------------------------
package tww_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int SEM_SLOTS_DEF  = 16;
    localparam int MAX_RESULTS    = 16;

    localparam int ACTION_W = 3;
    localparam int IDX_W    = 4;
    localparam int AMOUNT_W = 16;
    localparam int COUNT_W  = 8;
    localparam int EV_W     = 2;
    localparam int LIMIT_W  = 5;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    localparam logic [ACTION_W-1:0] ACT_SCAN      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CREATE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WAIT_TIME = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WAIT_SEM  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SIGNAL    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PRESET    = 3'd5;

    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_SIGNAL  = 2'd1;
    localparam logic [EV_W-1:0] EV_TIMEOUT = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic                wsem;
        logic                wtime;
        logic [IDX_W-1:0]    sem_sel;
        logic [AMOUNT_W-1:0] timer;
        logic [EV_W-1:0]     wake_ev;
    } t_task_entry;

    localparam int ENTRY_W = $bits(t_task_entry);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                tok;
        logic                create_ok;
        logic                sem_ok;
        logic [IDX_W-1:0]    sem_idx;
        logic [COUNT_W-1:0]  sem_cnt;
        logic [LIMIT_W-1:0]  limit;
        logic [AMOUNT_W-1:0] amount;
        t_task_entry         entry;
    } t_unit_in;

    typedef struct packed {
        logic               task_we;
        t_task_entry        entry;
        logic               sem_we;
        logic [COUNT_W-1:0] sem_wdata;
        logic               rdy;
        logic [EV_W-1:0]    ev;
        logic               status;
    } t_unit_out;

endpackage

FILE: hdl/task_wait_wakeup_scheduler.sv
// ----------------------------------------------------------------------------
// task_wait_wakeup_scheduler
// Hardware kernel of a cooperative scheduler: task table, semaphore counts,
// waits, signals and tick scans.
// ----------------------------------------------------------------------------
// One request is taken at a time. Create, wait, signal, preset and unused
// codes pass accept, RAM read and update steps and give one result. A tick
// scan visits every present task: the slot is read from the task RAM, then
// its awaited semaphore from the semaphore RAM, then the shared update unit
// writes the entry back, and the count where the unit asks for it, and loads
// the output register. Each RAM has a single read port. A scan of an empty
// table gives no result; a stalled output holds the update step. Semaphore
// counts read zero until first written, so no clearing pass follows reset.
module task_wait_wakeup_scheduler
    import tww_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int SEM_SLOTS  = SEM_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // action[2:0], task_req[6:3], sem[10:7], amount[26:11]
    input  logic [IN_W-1:0]    i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // task_slot[3:0], ready_res[4], wake_event[6:5], status[7]
    output logic [OUT_W-1:0]   o_m_axis_tdata,
    output logic               o_m_axis_tlast
);

    localparam int TW = $clog2(TASK_SLOTS);
    localparam int SW = $clog2(SEM_SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SEMRD, S_UPD} t_state;

    t_state              r_state;
    logic [LIMIT_W-1:0]  r_limit;
    logic [ACTION_W-1:0] r_action;
    logic [IDX_W-1:0]    r_task;
    logic [IDX_W-1:0]    r_sem;
    logic [AMOUNT_W-1:0] r_amount;
    logic [TW-1:0]       r_idx;
    logic [TW:0]         r_next_slot;
    logic [SEM_SLOTS-1:0] r_sem_vld;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_last;

    logic                s_acc;
    logic                is_scan;
    logic                tok;
    logic                create_ok;
    logic                emit;
    logic                stall;
    logic                out_load;
    logic                last_slot;
    logic [IDX_W-1:0]    sem_idx4;
    logic [SW-1:0]       sem_raddr;
    logic                sem_ok;
    logic [COUNT_W-1:0]  sem_rdata;
    logic [COUNT_W-1:0]  sem_cnt;
    logic [ENTRY_W-1:0]  task_rdata;
    t_task_entry         entry;
    logic [TW-1:0]       task_raddr;
    logic [TW-1:0]       task_waddr;
    logic                task_we;
    logic                sem_we;
    logic [IDX_W-1:0]    slot_out;
    t_unit_in            u_in;
    t_unit_out           u_out;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    assign is_scan   = (r_action == ACT_SCAN);
    assign tok       = (int'(r_task) < int'(r_next_slot));
    assign create_ok = (int'(r_next_slot) < TASK_SLOTS);
    assign entry     = t_task_entry'(task_rdata);
    assign last_slot = (int'(r_idx) == int'(r_next_slot) - 1)
                       || (int'(r_idx) == TASK_SLOTS - 1);

    assign sem_idx4  = (r_state == S_SEMRD || (r_state == S_UPD && is_scan))
                       ? entry.sem_sel : r_sem;
    assign sem_raddr = SW'(sem_idx4);
    assign sem_ok    = (int'(sem_idx4) < SEM_SLOTS);
    assign sem_cnt   = (sem_ok && r_sem_vld[sem_raddr]) ? sem_rdata : '0;

    assign task_raddr = is_scan ? r_idx : TW'(r_task);
    assign task_waddr = (r_action == ACT_CREATE) ? r_next_slot[TW-1:0] : task_raddr;

    assign emit     = !is_scan || (int'(r_idx) < MAX_RESULTS);
    assign stall    = emit && r_out_valid && !i_m_axis_tready;
    assign out_load = (r_state == S_UPD) && !stall && emit;

    assign task_we = (r_state == S_UPD) && !stall && u_out.task_we;
    assign sem_we  = (r_state == S_UPD) && !stall && u_out.sem_we;

    always_comb begin
        u_in.action    = r_action;
        u_in.tok       = tok;
        u_in.create_ok = create_ok;
        u_in.sem_ok    = sem_ok;
        u_in.sem_idx   = sem_idx4;
        u_in.sem_cnt   = sem_cnt;
        u_in.limit     = r_limit;
        u_in.amount    = r_amount;
        u_in.entry     = entry;
    end

    always_comb begin
        case (r_action)
            ACT_SCAN:      slot_out = IDX_W'(r_idx);
            ACT_CREATE:    slot_out = create_ok ? IDX_W'(r_next_slot) : '0;
            ACT_WAIT_TIME: slot_out = r_task;
            ACT_WAIT_SEM:  slot_out = r_task;
            default:       slot_out = '0;
        endcase
    end

    tww_slot_unit u_unit (
        .i_req (u_in),
        .o_res (u_out)
    );

    tww_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (u_out.entry),
        .i_re    (r_state == S_READ),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata)
    );

    tww_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (SEM_SLOTS)
    ) u_sem_ram (
        .i_clk   (i_clk),
        .i_we    (sem_we),
        .i_waddr (sem_raddr),
        .i_wdata (u_out.sem_wdata),
        .i_re    ((r_state == S_READ) || (r_state == S_SEMRD)),
        .i_raddr (sem_raddr),
        .o_rdata (sem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_next_slot <= '0;
            r_sem_vld   <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (sem_we) begin
                r_sem_vld[sem_raddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_action <= i_s_axis_tdata[2:0];
                        r_task   <= i_s_axis_tdata[6:3];
                        r_sem    <= i_s_axis_tdata[10:7];
                        r_amount <= i_s_axis_tdata[26:11];
                        r_idx    <= '0;
                        if (i_s_axis_tdata[2:0] == ACT_SCAN && r_next_slot == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= is_scan ? S_SEMRD : S_UPD;
                end
                S_SEMRD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!stall) begin
                        if (emit) begin
                            r_out_data  <= {u_out.status, u_out.ev, u_out.rdy, slot_out};
                            r_out_last  <= !is_scan || last_slot
                                           || (int'(r_idx) == MAX_RESULTS - 1);
                        end
                        if (r_action == ACT_CREATE && create_ok) begin
                            r_next_slot <= r_next_slot + 1'b1;
                        end
                        if (is_scan && !last_slot) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_next_slot) <= TASK_SLOTS)
        else $error("task slot count beyond table size");

    a_sem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sem_we |-> sem_ok)
        else $error("semaphore write outside range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tdata[2:0] != ACT_SCAN) |=> (r_state == S_READ))
        else $error("request accepted without starting work");

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> (!task_we && !sem_we))
        else $error("state written while result is stalled");

endmodule

FILE: hdl/tww_ram.sv
// ----------------------------------------------------------------------------
// tww_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tww_slot_unit.sv
// ----------------------------------------------------------------------------
// tww_slot_unit
// Shared update unit: computes the new task entry, semaphore count and
// result fields for one slot visit or one action.
// ----------------------------------------------------------------------------
module tww_slot_unit
    import tww_pkg::*;
(
    input  t_unit_in  i_req,
    output t_unit_out o_res
);

    logic        cnt_nz;
    logic        ge_limit;
    t_task_entry e;

    assign cnt_nz   = (i_req.sem_cnt != '0);
    assign ge_limit = ({1'b0, i_req.sem_idx} >= i_req.limit);

    always_comb begin
        e     = i_req.entry;
        o_res = '0;
        o_res.entry = e;
        case (i_req.action)
            ACT_SCAN: begin
                o_res.task_we = 1'b1;
                if (e.wsem && cnt_nz) begin
                    o_res.sem_we    = ge_limit;
                    o_res.sem_wdata = i_req.sem_cnt - 1'b1;
                    e.wake_ev = EV_SIGNAL;
                    e.wsem    = 1'b0;
                    e.wtime   = 1'b0;
                end
                if (e.wtime && (e.timer != '0)) begin
                    if (e.timer <= i_req.amount) begin
                        e.timer   = '0;
                        e.wake_ev = EV_TIMEOUT;
                        e.wsem    = 1'b0;
                        e.wtime   = 1'b0;
                    end else begin
                        e.timer = e.timer - i_req.amount;
                    end
                end
                o_res.entry = e;
                o_res.rdy   = !e.wsem && !e.wtime;
                o_res.ev    = e.wake_ev;
            end
            ACT_CREATE: begin
                o_res.task_we = i_req.create_ok;
                o_res.entry   = '0;
                o_res.status  = !i_req.create_ok;
            end
            ACT_WAIT_TIME: begin
                o_res.task_we     = i_req.tok;
                o_res.entry.wsem  = 1'b0;
                o_res.entry.wtime = 1'b1;
                o_res.entry.timer = i_req.amount;
                o_res.ev          = i_req.tok ? e.wake_ev : EV_NONE;
            end
            ACT_WAIT_SEM: begin
                o_res.task_we = i_req.tok;
                o_res.ev      = i_req.tok ? e.wake_ev : EV_NONE;
                if (cnt_nz) begin
                    o_res.sem_we      = i_req.tok;
                    o_res.sem_wdata   = i_req.sem_cnt - 1'b1;
                    o_res.entry.wsem  = 1'b0;
                    o_res.entry.wtime = 1'b0;
                    o_res.rdy         = i_req.tok;
                end else begin
                    o_res.entry.wsem    = 1'b1;
                    o_res.entry.sem_sel = i_req.sem_idx;
                    o_res.entry.wtime   = (i_req.amount != '0);
                    if (i_req.amount != '0) begin
                        o_res.entry.timer = i_req.amount;
                    end
                end
            end
            ACT_SIGNAL: begin
                o_res.sem_we    = i_req.sem_ok && (i_req.sem_cnt != COUNT_MAX);
                o_res.sem_wdata = i_req.sem_cnt + 1'b1;
            end
            ACT_PRESET: begin
                o_res.sem_we    = i_req.sem_ok;
                o_res.sem_wdata = i_req.amount[COUNT_W-1:0];
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule
